// File: hw/rtl/nfsa_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the nearest free slot allocator.
// No dependencies; the top level refers to this package by scoped names.
package nfsa_pkg;

  localparam int ROWS_DEF   = 10;
  localparam int COLS_DEF   = 5;
  localparam int TAG_W      = 64;
  localparam int SLOT_NUM_W = 6;
  localparam int OUTCOME_W  = 2;

  localparam logic [OUTCOME_W-1:0] OUT_DONE      = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_FULL      = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_NOT_FOUND = 2'd2;

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

endpackage

// File: hw/rtl/nearest_free_slot_allocator_unit.sv
`timescale 1ns / 1ps
// Nearest free slot allocator: an accepted start transfer steps the sequencer through the
// scan, drain and done states before the registered out_valid strobe, and busy stays high
// until that strobe cycle, so a new transfer is taken only once the last one is through. The scan
// walks one slot per cycle through the single tag memory read port and one shared
// distance/tag compare. Synchronous active-low reset frees every slot at once; the
// receiver cannot stall, and each result is shown for exactly one cycle.
// Depends on nfsa_pkg.
module nearest_free_slot_allocator_unit #(
  parameter int ROWS = nfsa_pkg::ROWS_DEF,
  parameter int COLS = nfsa_pkg::COLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_mode,
  input  logic [nfsa_pkg::TAG_W-1:0]      in_car_tag,
  output logic                            out_valid,
  output logic [nfsa_pkg::SLOT_NUM_W-1:0] out_slot_number,
  output logic [nfsa_pkg::OUTCOME_W-1:0]  out_outcome
);

  localparam int SLOTS  = ROWS * COLS;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int DIST_W = $clog2(ROWS + COLS);
  localparam int NUM_W  = IDX_W + 1;

  // Sequencer and item context
  nfsa_pkg::state_t state_r, state_nxt;
  logic                       mode_r;
  logic [nfsa_pkg::TAG_W-1:0] tag_r;

  // Scan position: flat index plus row and column, so distance needs no divide
  logic [IDX_W-1:0] cnt_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;

  // Compare stage, registered alongside the memory read data
  logic              p_vld_r;
  logic [IDX_W-1:0]  p_idx_r;
  logic [DIST_W-1:0] p_dist_r;

  // Running best / last match
  logic              found_vld_r;
  logic [IDX_W-1:0]  found_idx_r;
  logic [DIST_W-1:0] best_r;

  // Slot store: occupied marks in flops cleared by reset, tags in a memory
  logic [SLOTS-1:0]           occ_r;
  logic [nfsa_pkg::TAG_W-1:0] tag_mem [SLOTS];
  logic [nfsa_pkg::TAG_W-1:0] tag_q_r;

  // Output registers
  logic                            out_valid_r;
  logic [nfsa_pkg::SLOT_NUM_W-1:0] out_slot_r;
  logic [nfsa_pkg::OUTCOME_W-1:0]  out_outcome_r;

  logic hit;
  logic last_slot;
  logic alloc_write;
  logic [NUM_W-1:0] found_num;

  assign busy            = (state_r != nfsa_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_slot_number = out_slot_r;
  assign out_outcome     = out_outcome_r;

  assign last_slot = (cnt_r == IDX_W'(SLOTS - 1));
  assign found_num = NUM_W'(found_idx_r) + NUM_W'(1);

  // Shared compare: free and nearer when allocating, occupied and same tag when releasing
  always_comb begin
    hit = 1'b0;
    if (p_vld_r) begin
      if (mode_r == nfsa_pkg::MODE_ALLOC) begin
        hit = !occ_r[p_idx_r] && (!found_vld_r || (p_dist_r < best_r));
      end else begin
        hit = occ_r[p_idx_r] && (tag_q_r == tag_r);
      end
    end
  end

  assign alloc_write = (state_r == nfsa_pkg::ST_DONE) && (mode_r == nfsa_pkg::MODE_ALLOC) &&
                       found_vld_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nfsa_pkg::ST_IDLE:  if (start) state_nxt = nfsa_pkg::ST_SCAN;
      nfsa_pkg::ST_SCAN:  if (last_slot) state_nxt = nfsa_pkg::ST_DRAIN;
      nfsa_pkg::ST_DRAIN: state_nxt = nfsa_pkg::ST_DONE;
      nfsa_pkg::ST_DONE:  state_nxt = nfsa_pkg::ST_IDLE;
      default:            state_nxt = nfsa_pkg::ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nfsa_pkg::ST_IDLE;
      p_vld_r     <= 1'b0;
      found_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
      occ_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == nfsa_pkg::ST_DONE);
      p_vld_r     <= (state_r == nfsa_pkg::ST_SCAN);
      if ((state_r == nfsa_pkg::ST_IDLE) && start) begin
        found_vld_r <= 1'b0;
      end else if (hit) begin
        found_vld_r <= 1'b1;
      end
      // Release drops the mark as it matches; allocate claims the winner at the end
      if (hit && (mode_r == nfsa_pkg::MODE_RELEASE)) begin
        occ_r[p_idx_r] <= 1'b0;
      end
      if (alloc_write) begin
        occ_r[found_idx_r] <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if ((state_r == nfsa_pkg::ST_IDLE) && start) begin
      mode_r <= in_mode;
      tag_r  <= in_car_tag;
      cnt_r  <= '0;
      row_r  <= '0;
      col_r  <= '0;
    end else if (state_r == nfsa_pkg::ST_SCAN) begin
      cnt_r <= cnt_r + IDX_W'(1);
      // advance column, wrap into next row
      if (col_r == COL_W'(COLS - 1)) begin
        col_r <= '0;
        row_r <= row_r + ROW_W'(1);
      end else begin
        col_r <= col_r + COL_W'(1);
      end
    end
    p_idx_r  <= cnt_r;
    p_dist_r <= DIST_W'(row_r) + DIST_W'(col_r) + DIST_W'(1);
    if (hit) begin
      found_idx_r <= p_idx_r;
      best_r      <= p_dist_r;
    end
    if (state_r == nfsa_pkg::ST_DONE) begin
      if (found_vld_r) begin
        out_slot_r    <= nfsa_pkg::SLOT_NUM_W'(found_num);
        out_outcome_r <= nfsa_pkg::OUT_DONE;
      end else begin
        out_slot_r    <= '0;
        out_outcome_r <= (mode_r == nfsa_pkg::MODE_ALLOC) ? nfsa_pkg::OUT_FULL :
                                                            nfsa_pkg::OUT_NOT_FOUND;
      end
    end
  end

  // Tag memory: one write port, one registered read port walked by the scan
  always_ff @(posedge clk) begin
    if (alloc_write) begin
      tag_mem[found_idx_r] <= tag_r;
    end
    tag_q_r <= tag_mem[cnt_r];
  end

  // Checks
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("sequencer state not one-hot");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accepted transfer did not raise busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_outcome != nfsa_pkg::OUT_DONE)) |-> (out_slot_number == '0))
    else $error("failed outcome with nonzero slot number");

  a_alloc_marks: assert property (@(posedge clk) disable iff (!rst_n)
    alloc_write |=> occ_r[$past(found_idx_r)])
    else $error("allocated slot not marked occupied");

endmodule
